// File: src/amcd_pkg.sv
`timescale 1ns / 1ps
// Shared constants for the adjacency matrix cycle detector.
// Field widths, item kind codes and the default vertex capacity. No dependencies.
package amcd_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam int KIND_W = 2;
  localparam int VERT_W = 4;

  localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd3;

endpackage

// File: src/adjacency_matrix_cycle_detect.sv
`timescale 1ns / 1ps
// Directed graph store with depth-first cycle check, top level.
// Depends on amcd_pkg for field widths, kind codes and the default capacity.

// Holds a directed graph of up to MAX_VERTICES vertices as a row memory of
// adjacency bits, cleared at reset through one valid bit per row. Every
// input beat yields exactly one result beat. Add, remove and query read the
// source row, then update or test it, then load the result register. A
// cycle check walks the graph depth-first with a single bit-scan step per
// cycle over the row of the vertex on top of the search stack: each push or
// pop rescans that row. The adjacency memory's single read port and the
// one-entry-a-cycle scan set the cost of a check. in_stall stays high until
// the result has moved into the output register; that register may still
// hold an earlier result waiting on out_stall while the next beat is taken.
module adjacency_matrix_cycle_detect #(
  parameter int MAX_VERTICES = amcd_pkg::MAX_VERTICES_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [amcd_pkg::KIND_W-1:0] in_kind,
  input  logic [amcd_pkg::VERT_W-1:0] in_src,
  input  logic [amcd_pkg::VERT_W-1:0] in_dst,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        out_answer
);

  localparam int VW   = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int CW   = $clog2(MAX_VERTICES + 1);
  localparam int IW   = amcd_pkg::VERT_W;
  localparam int CMPW = (CW > IW) ? CW : IW;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_OP   = 3'd1;
  localparam logic [2:0] S_ROOT = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;
  localparam logic [2:0] S_FIN  = 3'd5;

  // control state
  logic [2:0]              state_r, state_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic [MAX_VERTICES-1:0] row_vld_r, row_vld_nxt;
  logic [MAX_VERTICES-1:0] visited_r, visited_nxt;
  logic [MAX_VERTICES-1:0] onstk_r, onstk_nxt;
  logic [CW-1:0]           depth_r, depth_nxt;
  logic                    out_valid_r;

  // datapath
  logic [amcd_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [IW-1:0]               src_r, src_nxt;
  logic [IW-1:0]               dst_r, dst_nxt;
  logic [CW-1:0]               root_r, root_nxt;
  logic [CW-1:0]               i_r, i_nxt;
  logic [VW-1:0]               top_r, top_nxt;
  logic                        ans_r, ans_nxt;
  logic                        out_answer_r;

  // memories
  logic [MAX_VERTICES-1:0] adj_mem [MAX_VERTICES];
  logic [VW-1:0]           stk_mem [MAX_VERTICES];
  logic [MAX_VERTICES-1:0] rd_data_r;
  logic                    rd_vld_r;
  logic [VW-1:0]           stk_rd_r;

  logic                    adj_we, adj_re;
  logic [VW-1:0]           adj_wa, adj_ra;
  logic [MAX_VERTICES-1:0] adj_wd;
  logic                    stk_we, stk_re;
  logic [VW-1:0]           stk_wa, stk_ra, stk_wd;

  logic [CMPW-1:0]         in_src_x, src_x, dst_x, count_x, hi_max;
  logic [CMPW:0]           hi;
  logic [VW-1:0]           src_idx, dst_idx, root_idx, i_idx, in_src_idx;
  logic [CW-1:0]           depth_m2;
  logic [MAX_VERTICES-1:0] row_eff, one_dst;
  logic                    in_cap, present, hit, out_free;

  assign in_src_x   = CMPW'(in_src);
  assign src_x      = CMPW'(src_r);
  assign dst_x      = CMPW'(dst_r);
  assign count_x    = CMPW'(count_r);
  assign in_src_idx = in_src_x[VW-1:0];
  assign src_idx    = src_x[VW-1:0];
  assign dst_idx    = dst_x[VW-1:0];
  assign root_idx   = root_r[VW-1:0];
  assign i_idx      = i_r[VW-1:0];
  assign depth_m2   = depth_r - CW'(2);

  assign in_cap  = (src_x < CMPW'(MAX_VERTICES)) && (dst_x < CMPW'(MAX_VERTICES));
  assign present = (src_x < count_x) && (dst_x < count_x);
  assign hi_max  = (src_x > dst_x) ? src_x : dst_x;
  assign hi      = {1'b0, hi_max} + (CMPW + 1)'(1);

  // a row never written reads as empty
  assign row_eff = rd_vld_r ? rd_data_r : '0;
  assign one_dst = {{(MAX_VERTICES-1){1'b0}}, 1'b1} << dst_idx;
  assign hit     = row_eff[i_idx];

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    row_vld_nxt = row_vld_r;
    visited_nxt = visited_r;
    onstk_nxt   = onstk_r;
    depth_nxt   = depth_r;
    kind_nxt    = kind_r;
    src_nxt     = src_r;
    dst_nxt     = dst_r;
    root_nxt    = root_r;
    i_nxt       = i_r;
    top_nxt     = top_r;
    ans_nxt     = ans_r;
    adj_we      = 1'b0;
    adj_wa      = src_idx;
    adj_wd      = row_eff;
    adj_re      = 1'b0;
    adj_ra      = in_src_idx;
    stk_we      = 1'b0;
    stk_wa      = depth_r[VW-1:0];
    stk_wd      = i_idx;
    stk_re      = 1'b0;
    stk_ra      = depth_m2[VW-1:0];

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt = in_kind;
          src_nxt  = in_src;
          dst_nxt  = in_dst;
          if (in_kind == amcd_pkg::KIND_CHECK) begin
            visited_nxt = '0;
            onstk_nxt   = '0;
            root_nxt    = '0;
            state_nxt   = S_ROOT;
          end else begin
            adj_re    = 1'b1;
            adj_ra    = in_src_idx;
            state_nxt = S_OP;
          end
        end
      end

      S_OP: begin
        ans_nxt = 1'b0;
        case (kind_r)
          amcd_pkg::KIND_ADD: begin
            if (in_cap) begin
              adj_we = 1'b1;
              adj_wd = row_eff | one_dst;
              if (hi > (CMPW + 1)'(count_r)) count_nxt = CW'(hi);
            end
          end
          amcd_pkg::KIND_REMOVE: begin
            if (present) begin
              adj_we = 1'b1;
              adj_wd = row_eff & ~one_dst;
            end
          end
          amcd_pkg::KIND_QUERY: begin
            ans_nxt = present && row_eff[dst_idx];
          end
          default: begin
            ans_nxt = 1'b0;
          end
        endcase
        state_nxt = S_FIN;
      end

      S_ROOT: begin
        if (root_r == count_r) begin
          ans_nxt   = 1'b0;
          state_nxt = S_FIN;
        end else if (visited_r[root_idx]) begin
          root_nxt = root_r + CW'(1);
        end else begin
          visited_nxt[root_idx] = 1'b1;
          onstk_nxt[root_idx]   = 1'b1;
          stk_we    = 1'b1;
          stk_wa    = '0;
          stk_wd    = root_idx;
          depth_nxt = CW'(1);
          top_nxt   = root_idx;
          adj_re    = 1'b1;
          adj_ra    = root_idx;
          i_nxt     = '0;
          state_nxt = S_SCAN;
        end
      end

      S_SCAN: begin
        if (i_r == count_r) begin
          // row exhausted: drop top and resume its parent
          onstk_nxt[top_r] = 1'b0;
          depth_nxt        = depth_r - CW'(1);
          if (depth_r == CW'(1)) begin
            root_nxt  = root_r + CW'(1);
            state_nxt = S_ROOT;
          end else begin
            stk_re    = 1'b1;
            stk_ra    = depth_m2[VW-1:0];
            state_nxt = S_POP;
          end
        end else if (hit && onstk_r[i_idx]) begin
          ans_nxt   = 1'b1;
          state_nxt = S_FIN;
        end else if (hit && !visited_r[i_idx]) begin
          visited_nxt[i_idx] = 1'b1;
          onstk_nxt[i_idx]   = 1'b1;
          stk_we    = 1'b1;
          stk_wa    = depth_r[VW-1:0];
          stk_wd    = i_idx;
          depth_nxt = depth_r + CW'(1);
          top_nxt   = i_idx;
          adj_re    = 1'b1;
          adj_ra    = i_idx;
          i_nxt     = '0;
        end else begin
          i_nxt = i_r + CW'(1);
        end
      end

      S_POP: begin
        top_nxt   = stk_rd_r;
        adj_re    = 1'b1;
        adj_ra    = stk_rd_r;
        i_nxt     = '0;
        state_nxt = S_SCAN;
      end

      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    if (adj_we) row_vld_nxt[adj_wa] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      row_vld_r   <= '0;
      visited_r   <= '0;
      onstk_r     <= '0;
      depth_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      count_r   <= count_nxt;
      row_vld_r <= row_vld_nxt;
      visited_r <= visited_nxt;
      onstk_r   <= onstk_nxt;
      depth_r   <= depth_nxt;
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r <= kind_nxt;
    src_r  <= src_nxt;
    dst_r  <= dst_nxt;
    root_r <= root_nxt;
    i_r    <= i_nxt;
    top_r  <= top_nxt;
    ans_r  <= ans_nxt;
    if (state_r == S_FIN && out_free) out_answer_r <= ans_r;
  end

  // adjacency rows, one write and one registered read port
  always_ff @(posedge clk) begin
    if (adj_we) adj_mem[adj_wa] <= adj_wd;
    if (adj_re) begin
      rd_data_r <= adj_mem[adj_ra];
      rd_vld_r  <= row_vld_r[adj_ra];
    end
  end

  // search stack
  always_ff @(posedge clk) begin
    if (stk_we) stk_mem[stk_wa] <= stk_wd;
    if (stk_re) stk_rd_r <= stk_mem[stk_ra];
  end

  assign in_stall   = (state_r != S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_answer = out_answer_r;

  a_onstk_visited: assert property (@(posedge clk) disable iff (!rst_n)
    (onstk_r & ~visited_r) == '0)
    else $error("on-stack vertex not marked visited");

  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    depth_r <= count_r)
    else $error("search depth exceeds vertex count");

  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(MAX_VERTICES))
    else $error("vertex count beyond capacity");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN || state_r == S_POP) |-> depth_r != '0)
    else $error("scan with empty search stack");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> (state_r != S_IDLE))
    else $error("accepted beat did not start work");

endmodule

// File: test/tb.sv
`timescale 1ns / 1ps
// Testbench for adjacency_matrix_cycle_detect: edge add, remove, query and cycle check beats
// checked against an in-bench graph model with its own depth-first search.
// Depends on amcd_pkg for field widths, kind codes and the vertex capacity.
module tb;

  localparam int NV          = amcd_pkg::MAX_VERTICES_DEF;
  localparam int CYCLE_LIMIT = 5_000_000;
  localparam int RANDOM_BEATS = 1900;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC} stall_mode_t;

  typedef struct {
    logic [amcd_pkg::KIND_W-1:0] kind;
    logic [amcd_pkg::VERT_W-1:0] src;
    logic [amcd_pkg::VERT_W-1:0] dst;
    logic                        answer;
  } answer_beat_t;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_stall;
  logic [amcd_pkg::KIND_W-1:0] in_kind;
  logic [amcd_pkg::VERT_W-1:0] in_src;
  logic [amcd_pkg::VERT_W-1:0] in_dst;
  logic                        out_valid;
  logic                        out_stall;
  logic                        out_answer;

  // graph model
  logic [NV-1:0] graph_rows [NV];
  int            present_count;

  answer_beat_t  pending_answers [$];
  int            mismatches;
  int            beats_sent;
  int            cycle_count;

  // pacing of both sides
  int            burst_left;
  bit            steady;
  stall_mode_t   stall_mode;
  int            stall_period;
  int            stall_duty;
  int            stall_tick;
  int            hold_req;
  int            hold_left;

  adjacency_matrix_cycle_detect DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_kind   (in_kind),
    .in_src    (in_src),
    .in_dst    (in_dst),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_answer(out_answer)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d answers outstanding", cycle_count,
               pending_answers.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // Depth-first search over present vertices; true on an arc into a vertex on the stack.
  function automatic logic graph_has_cycle();
    logic [NV-1:0] seen;
    logic [NV-1:0] on_path;
    int            path [NV];
    int            depth;
    int            top;
    int            root;
    int            i;
    bit            pushed;
    seen    = '0;
    on_path = '0;
    for (root = 0; root < present_count; root++) begin
      if (seen[root]) continue;
      seen[root]    = 1'b1;
      on_path[root] = 1'b1;
      path[0]       = root;
      depth         = 1;
      while (depth > 0) begin
        top    = path[depth-1];
        pushed = 1'b0;
        for (i = 0; i < present_count; i++) begin
          if (!graph_rows[top][i]) continue;
          if (on_path[i]) return 1'b1;
          if (!seen[i]) begin
            seen[i]     = 1'b1;
            on_path[i]  = 1'b1;
            path[depth] = i;
            depth++;
            pushed = 1'b1;
            break;
          end
        end
        if (!pushed) begin
          on_path[top] = 1'b0;
          depth--;
        end
      end
    end
    return 1'b0;
  endfunction

  // Apply one beat to the model and return the answer it should produce.
  function automatic logic apply_to_graph(logic [amcd_pkg::KIND_W-1:0] kind,
                                          logic [amcd_pkg::VERT_W-1:0] src,
                                          logic [amcd_pkg::VERT_W-1:0] dst);
    int hi;
    hi = ((src > dst) ? int'(src) : int'(dst)) + 1;
    case (kind)
      amcd_pkg::KIND_ADD: begin
        graph_rows[src][dst] = 1'b1;
        if (hi > present_count) present_count = hi;
        return 1'b0;
      end
      amcd_pkg::KIND_REMOVE: begin
        if (src < present_count && dst < present_count) graph_rows[src][dst] = 1'b0;
        return 1'b0;
      end
      amcd_pkg::KIND_QUERY: begin
        if (src < present_count && dst < present_count) return graph_rows[src][dst];
        return 1'b0;
      end
      default: return graph_has_cycle();
    endcase
  endfunction

  task automatic report_mismatch(string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // Offer one beat and hold it until accepted; called at a rising edge.
  task automatic send_beat(logic [amcd_pkg::KIND_W-1:0] kind,
                           logic [amcd_pkg::VERT_W-1:0] src,
                           logic [amcd_pkg::VERT_W-1:0] dst);
    answer_beat_t exp_beat;
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_src   <= src;
    in_dst   <= dst;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_beat.kind   = kind;
    exp_beat.src    = src;
    exp_beat.dst    = dst;
    exp_beat.answer = apply_to_graph(kind, src, dst);
    pending_answers.push_back(exp_beat);
    beats_sent++;
  endtask

  task automatic go_idle(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  // Bursts of random length, with random gaps between them unless steady is set.
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if (!steady) go_idle($urandom_range(1, 8));
    end
  endtask

  task automatic send_paced(logic [amcd_pkg::KIND_W-1:0] kind,
                            logic [amcd_pkg::VERT_W-1:0] src,
                            logic [amcd_pkg::VERT_W-1:0] dst);
    send_beat(kind, src, dst);
    pace();
  endtask

  task automatic wait_results_in();
    go_idle(1);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  // Receiver: a long hold-off on request, otherwise the current stall pattern.
  always @(posedge clk) begin
    stall_tick++;
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_NONE:   out_stall <= 1'b0;
        STALL_RANDOM: out_stall <= ($urandom_range(0, 2) == 0);
        default:      out_stall <= ((stall_tick % stall_period) < stall_duty);
      endcase
    end
  end

  always @(posedge clk) begin
    answer_beat_t exp_beat;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_answers.size() == 0) begin
        report_mismatch($sformatf("answer beat %0b with nothing expected", out_answer));
      end else begin
        exp_beat = pending_answers.pop_front();
        if (out_answer !== exp_beat.answer)
          report_mismatch($sformatf("kind %0d src %0d dst %0d: answer %b, want %b",
                                    exp_beat.kind, exp_beat.src, exp_beat.dst,
                                    out_answer, exp_beat.answer));
      end
    end
  end

  task automatic pick_pacing();
    stall_mode   = stall_mode_t'($urandom_range(0, 2));
    stall_period = $urandom_range(2, 9);
    stall_duty   = $urandom_range(1, stall_period - 1);
    steady       = ($urandom_range(0, 4) == 0);
  endtask

  task automatic test_empty_graph();
    send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
    send_paced(amcd_pkg::KIND_QUERY, 4'd0, 4'd0);
    send_paced(amcd_pkg::KIND_REMOVE, 4'd0, 4'd0);
    send_paced(amcd_pkg::KIND_QUERY, 4'd15, 4'd15);
  endtask

  task automatic test_absent_vertex();
    send_paced(amcd_pkg::KIND_ADD, 4'd1, 4'd2);
    send_paced(amcd_pkg::KIND_QUERY, 4'd1, 4'd2);
    send_paced(amcd_pkg::KIND_QUERY, 4'd5, 4'd1);
    send_paced(amcd_pkg::KIND_REMOVE, 4'd1, 4'd5);
    send_paced(amcd_pkg::KIND_QUERY, 4'd2, 4'd1);
    send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
  endtask

  task automatic test_self_loop();
    send_paced(amcd_pkg::KIND_ADD, 4'd2, 4'd2);
    send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
    send_paced(amcd_pkg::KIND_REMOVE, 4'd2, 4'd2);
    send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
  endtask

  task automatic test_back_arc();
    send_paced(amcd_pkg::KIND_ADD, 4'd2, 4'd1);
    send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
    send_paced(amcd_pkg::KIND_REMOVE, 4'd1, 4'd2);
    send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
    send_paced(amcd_pkg::KIND_REMOVE, 4'd2, 4'd1);
  endtask

  task automatic test_extreme_vertices();
    send_paced(amcd_pkg::KIND_ADD, 4'd15, 4'd0);
    send_paced(amcd_pkg::KIND_QUERY, 4'd15, 4'd0);
    send_paced(amcd_pkg::KIND_QUERY, 4'd0, 4'd15);
    send_paced(amcd_pkg::KIND_ADD, 4'd0, 4'd15);
    send_paced(amcd_pkg::KIND_CHECK, 4'd15, 4'd15);
    send_paced(amcd_pkg::KIND_REMOVE, 4'd0, 4'd15);
    send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
  endtask

  // Hold the receiver off while the sender keeps offering, so the block backs up.
  task automatic test_backpressure();
    int k;
    wait_results_in();
    hold_req = 400;
    for (k = 0; k < 6; k++)
      send_beat(amcd_pkg::KIND_QUERY, 4'($urandom_range(0, NV-1)),
                4'($urandom_range(0, NV-1)));
    send_beat(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
    wait_results_in();
  endtask

  // Rounds: clear the graph, build a DAG on shuffled labels, maybe plant a back arc,
  // check, undo the back arc, check again; queries and noise mixed in.
  task automatic test_random_graphs(int target);
    int first_beat;
    int order [NV];
    int n, m, k, a, b, tmp, s, d;
    bit planted;
    first_beat = beats_sent;
    while (beats_sent - first_beat < target) begin
      pick_pacing();
      for (s = 0; s < NV; s++)
        for (d = 0; d < NV; d++)
          if (graph_rows[s][d]) send_paced(amcd_pkg::KIND_REMOVE, 4'(s), 4'(d));
      for (k = 0; k < NV; k++) order[k] = k;
      for (k = NV - 1; k > 0; k--) begin
        a        = $urandom_range(0, k);
        tmp      = order[k];
        order[k] = order[a];
        order[a] = tmp;
      end
      n = ($urandom_range(0, 3) != 0) ? $urandom_range(2, 6) : $urandom_range(7, NV);
      m = $urandom_range(n - 1, 2 * n);
      for (k = 0; k < m; k++) begin
        a = $urandom_range(0, n - 2);
        b = $urandom_range(a + 1, n - 1);
        send_paced(amcd_pkg::KIND_ADD, 4'(order[a]), 4'(order[b]));
        if ($urandom_range(0, 3) == 0)
          send_paced(amcd_pkg::KIND_QUERY, 4'(order[$urandom_range(0, n - 1)]),
                     4'(order[$urandom_range(0, n - 1)]));
        if ($urandom_range(0, 9) == 0)
          send_paced(2'($urandom_range(0, 3)), 4'($urandom_range(0, NV - 1)),
                     4'($urandom_range(0, NV - 1)));
      end
      planted = $urandom_range(0, 1);
      if (planted) begin
        b = $urandom_range(0, n - 1);
        a = $urandom_range(b, n - 1);
        send_paced(amcd_pkg::KIND_ADD, 4'(order[a]), 4'(order[b]));
      end
      send_paced(amcd_pkg::KIND_CHECK, 4'($urandom_range(0, NV - 1)),
                 4'($urandom_range(0, NV - 1)));
      if (planted) begin
        send_paced(amcd_pkg::KIND_QUERY, 4'(order[a]), 4'(order[b]));
        send_paced(amcd_pkg::KIND_REMOVE, 4'(order[a]), 4'(order[b]));
        send_paced(amcd_pkg::KIND_CHECK, 4'd0, 4'd0);
      end
      for (k = 0; k < 3; k++)
        send_paced(amcd_pkg::KIND_QUERY, 4'($urandom_range(0, NV - 1)),
                   4'($urandom_range(0, NV - 1)));
      if ($urandom_range(0, 7) == 0) wait_results_in();
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = amcd_pkg::KIND_ADD;
    in_src        = '0;
    in_dst        = '0;
    out_stall     = 1'b0;
    mismatches    = 0;
    beats_sent    = 0;
    cycle_count   = 0;
    burst_left    = 0;
    steady        = 1'b0;
    stall_mode    = STALL_RANDOM;
    stall_period  = 4;
    stall_duty    = 1;
    stall_tick    = 0;
    hold_req      = 0;
    hold_left     = 0;
    present_count = 0;
    for (int r = 0; r < NV; r++) graph_rows[r] = '0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_graph();
    test_absent_vertex();
    test_self_loop();
    test_back_arc();
    test_extreme_vertices();
    test_backpressure();
    test_random_graphs(RANDOM_BEATS);

    wait_results_in();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && pending_answers.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
